### rtl/gta_pkg.sv
// shared constants and types for the greedy track association block
// no dependencies

package gta_pkg;

    localparam int NUM_TRACKS_DEF = 6;
    localparam int COORD_BITS_DEF = 16;
    localparam int IDX_OUT_W      = 3;
    localparam int QUEUE_DEPTH    = 4;

    // what the back end has to do with one queued request
    typedef struct packed {
        logic store;   // request carries a centroid
        logic close;   // request closes the frame
    } gta_cmd_t;

    localparam int CMD_W = $bits(gta_cmd_t);

endpackage

### rtl/gta_front.sv
// front end: accepts input requests, classifies them and pushes those with a centroid or a frame end to the queue
// depends on gta_pkg

module gta_front import gta_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COORD_BITS-1:0]      s_centroid_x,
    input  logic signed [COORD_BITS-1:0]      s_centroid_y,
    input  logic                              s_point_valid,
    input  logic                              s_frame_end,
    input  logic                              q_full,
    output logic                              q_push,
    output logic [CMD_W+2*COORD_BITS-1:0]     q_push_data
);

    gta_cmd_t cmd;

    assign s_ready = !q_full;

    always_comb begin
        cmd.store = s_point_valid;
        cmd.close = s_frame_end;
    end

    // requests with neither a centroid nor a frame end are dropped here
    assign q_push      = s_valid && s_ready && (cmd.store || cmd.close);
    assign q_push_data = {cmd, s_centroid_x, s_centroid_y};

endmodule

### rtl/gta_queue.sv
// short fifo between the front and back ends
// depends on gta_pkg

module gta_queue import gta_pkg::*; #(
    parameter int DATA_W = CMD_W + 2 * COORD_BITS_DEF,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/gta_back.sv
// back end: frame buffer, track table, pipelined nearest-centroid search, result register
// depends on gta_pkg

module gta_back import gta_pkg::*; #(
    parameter int NUM_TRACKS = NUM_TRACKS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    input  gta_cmd_t                     q_cmd,
    input  logic signed [COORD_BITS-1:0] q_x,
    input  logic signed [COORD_BITS-1:0] q_y,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [IDX_OUT_W-1:0]         m_track_index,
    output logic [IDX_OUT_W-1:0]         m_cluster_index,
    output logic signed [COORD_BITS-1:0] m_track_x,
    output logic signed [COORD_BITS-1:0] m_track_y,
    output logic                         m_last_result
);

    localparam int IDX_W  = $clog2(NUM_TRACKS);
    localparam int CNT_W  = $clog2(NUM_TRACKS + 1);
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = SQ_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TRACKS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLOSE = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic signed [COORD_BITS-1:0] frame_x_reg [NUM_TRACKS];
    logic signed [COORD_BITS-1:0] frame_y_reg [NUM_TRACKS];
    logic signed [COORD_BITS-1:0] track_x_reg [NUM_TRACKS];
    logic signed [COORD_BITS-1:0] track_y_reg [NUM_TRACKS];
    logic [CNT_W-1:0]             fill_reg;
    logic [NUM_TRACKS-1:0]        used_reg;
    logic                         first_reg;
    logic [IDX_W-1:0]             t_reg;
    logic [IDX_W-1:0]             c_reg;

    // stage a: absolute differences
    logic                         a_vld_reg;
    logic                         a_cand_reg;
    logic [IDX_W-1:0]             a_idx_reg;
    logic [COORD_BITS-1:0]        a_dx_reg;
    logic [COORD_BITS-1:0]        a_dy_reg;
    logic signed [COORD_BITS-1:0] a_x_reg;
    logic signed [COORD_BITS-1:0] a_y_reg;
    // stage b: squares
    logic                         b_vld_reg;
    logic                         b_cand_reg;
    logic [IDX_W-1:0]             b_idx_reg;
    logic [SQ_W-1:0]              b_sx_reg;
    logic [SQ_W-1:0]              b_sy_reg;
    logic signed [COORD_BITS-1:0] b_x_reg;
    logic signed [COORD_BITS-1:0] b_y_reg;
    // running best of the current track
    logic                         best_found_reg;
    logic [DIST_W-1:0]            best_dist_reg;
    logic [IDX_W-1:0]             best_idx_reg;
    logic signed [COORD_BITS-1:0] best_x_reg;
    logic signed [COORD_BITS-1:0] best_y_reg;
    // result register
    logic                         m_valid_reg;
    logic [IDX_OUT_W-1:0]         m_tidx_reg;
    logic [IDX_OUT_W-1:0]         m_cidx_reg;
    logic signed [COORD_BITS-1:0] m_x_reg;
    logic signed [COORD_BITS-1:0] m_y_reg;
    logic                         m_last_reg;

    logic signed [COORD_BITS:0]   dx_full;
    logic signed [COORD_BITS:0]   dy_full;
    logic [COORD_BITS-1:0]        dx_mag;
    logic [COORD_BITS-1:0]        dy_mag;
    logic [SQ_W-1:0]              sx_w;
    logic [SQ_W-1:0]              sy_w;
    logic [DIST_W-1:0]            dist_w;
    logic                         take_best;
    logic                         pop_now;
    logic                         store_now;
    logic                         out_free;
    logic                         emit_now;
    logic                         new_track;
    logic [IDX_W+IDX_OUT_W-1:0]   t_ext;
    logic [IDX_W+IDX_OUT_W-1:0]   best_ext;

    assign pop_now   = (state_reg == ST_IDLE) && q_valid;
    assign q_pop     = pop_now;
    assign store_now = pop_now && q_cmd.store && (fill_reg < CNT_W'(NUM_TRACKS));
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_now  = (state_reg == ST_EMIT) && out_free;
    assign new_track = ((state_reg == ST_CLOSE) && !first_reg)
                    || (emit_now && (t_reg != LAST_IDX));

    // signed differences, one extra bit so they never wrap
    always_comb begin
        dx_full = (COORD_BITS+1)'(track_x_reg[t_reg]) - (COORD_BITS+1)'(frame_x_reg[c_reg]);
        dy_full = (COORD_BITS+1)'(track_y_reg[t_reg]) - (COORD_BITS+1)'(frame_y_reg[c_reg]);
        dx_mag  = dx_full[COORD_BITS] ? COORD_BITS'(-dx_full) : COORD_BITS'(dx_full);
        dy_mag  = dy_full[COORD_BITS] ? COORD_BITS'(-dy_full) : COORD_BITS'(dy_full);
    end

    assign sx_w   = a_dx_reg * a_dx_reg;
    assign sy_w   = a_dy_reg * a_dy_reg;
    assign dist_w = {1'b0, b_sx_reg} + {1'b0, b_sy_reg};
    // strict compare keeps the lowest index on ties
    assign take_best = b_vld_reg && b_cand_reg && (!best_found_reg || dist_w < best_dist_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop_now && q_cmd.close) state_next = ST_CLOSE;
            end
            ST_CLOSE: begin
                state_next = first_reg ? ST_IDLE : ST_SCAN;
            end
            ST_SCAN: begin
                if (c_reg == LAST_IDX) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!a_vld_reg && !b_vld_reg) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) state_next = (t_reg == LAST_IDX) ? ST_IDLE : ST_SCAN;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            used_reg       <= '0;
            first_reg      <= 1'b1;
            t_reg          <= '0;
            c_reg          <= '0;
            a_vld_reg      <= 1'b0;
            b_vld_reg      <= 1'b0;
            best_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_TRACKS; i++) begin
                frame_x_reg[i] <= '0;
                frame_y_reg[i] <= '0;
                track_x_reg[i] <= '0;
                track_y_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            a_vld_reg <= (state_reg == ST_SCAN);
            b_vld_reg <= a_vld_reg;

            if (store_now) begin
                frame_x_reg[fill_reg[IDX_W-1:0]] <= q_x;
                frame_y_reg[fill_reg[IDX_W-1:0]] <= q_y;
                fill_reg <= fill_reg + 1'b1;
            end

            if (state_reg == ST_CLOSE) begin
                t_reg    <= '0;
                used_reg <= '0;
                if (first_reg) begin
                    first_reg <= 1'b0;
                    fill_reg  <= '0;
                    for (int i = 0; i < NUM_TRACKS; i++) begin
                        track_x_reg[i] <= frame_x_reg[i];
                        track_y_reg[i] <= frame_y_reg[i];
                        frame_x_reg[i] <= '0;
                        frame_y_reg[i] <= '0;
                    end
                end
            end

            if (state_reg == ST_SCAN) begin
                c_reg <= c_reg + 1'b1;
            end
            if (new_track) begin
                c_reg <= '0;
            end

            if (new_track) begin
                best_found_reg <= 1'b0;
            end else if (take_best) begin
                best_found_reg <= 1'b1;
            end

            if (emit_now) begin
                used_reg[best_idx_reg] <= 1'b1;
                track_x_reg[t_reg]     <= best_x_reg;
                track_y_reg[t_reg]     <= best_y_reg;
                t_reg                  <= t_reg + 1'b1;
                if (t_reg == LAST_IDX) begin
                    fill_reg <= '0;
                    for (int i = 0; i < NUM_TRACKS; i++) begin
                        frame_x_reg[i] <= '0;
                        frame_y_reg[i] <= '0;
                    end
                end
            end

            if (emit_now) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath without reset
    always_ff @(posedge aclk) begin
        a_cand_reg <= !used_reg[c_reg];
        a_idx_reg  <= c_reg;
        a_dx_reg   <= dx_mag;
        a_dy_reg   <= dy_mag;
        a_x_reg    <= frame_x_reg[c_reg];
        a_y_reg    <= frame_y_reg[c_reg];

        b_cand_reg <= a_cand_reg;
        b_idx_reg  <= a_idx_reg;
        b_sx_reg   <= sx_w;
        b_sy_reg   <= sy_w;
        b_x_reg    <= a_x_reg;
        b_y_reg    <= a_y_reg;

        if (take_best) begin
            best_dist_reg <= dist_w;
            best_idx_reg  <= b_idx_reg;
            best_x_reg    <= b_x_reg;
            best_y_reg    <= b_y_reg;
        end
    end

    assign t_ext    = {{IDX_OUT_W{1'b0}}, t_reg};
    assign best_ext = {{IDX_OUT_W{1'b0}}, best_idx_reg};

    always_ff @(posedge aclk) begin
        if (emit_now) begin
            m_tidx_reg <= t_ext[IDX_OUT_W-1:0];
            m_cidx_reg <= best_ext[IDX_OUT_W-1:0];
            m_x_reg    <= best_x_reg;
            m_y_reg    <= best_y_reg;
            m_last_reg <= (t_reg == LAST_IDX);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_track_index   = m_tidx_reg;
    assign m_cluster_index = m_cidx_reg;
    assign m_track_x       = m_x_reg;
    assign m_track_y       = m_y_reg;
    assign m_last_result   = m_last_reg;

endmodule

### rtl/greedy_track_association.sv
// top level of the greedy nearest-neighbor track association block
// depends on gta_pkg, gta_front, gta_queue, gta_back
//
// usage
//  - s_ channel: one request per centroid (s_point_valid) and/or frame close
//    (s_frame_end); a request with neither flag is taken and ignored
//  - at most NUM_TRACKS centroids are kept per frame, missing ones count as zero
//  - the first frame after reset only loads the track table, no results
//  - every later frame close yields NUM_TRACKS results on the m_ channel,
//    tracks in order, m_last_result set on the final one
// request flow and search
//  - s_ready stays high while the request queue has room: one request a cycle
//    until the queue fills while the back end is busy with an association pass
//  - a request enters the queue at its handshake and reaches the back end once
//    it heads the queue and the back end is idle; a centroid is then stored in
//    the frame buffer, while a frame close passes through a close state first
//  - each track then scans every candidate, one a cycle, through a two-register
//    distance pipeline (absolute differences, squares), drains the pipeline and
//    hands its result over to the result register
// reset and stalls
//  - synchronous active-low reset empties the queue, clears tracks and frame
//    buffer and re-arms the first-frame load
//  - a stalled receiver holds the result register; the search for the next
//    track waits in its hand-over cycle, while the front keeps queueing requests

module greedy_track_association import gta_pkg::*; #(
    parameter int NUM_TRACKS = NUM_TRACKS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_centroid_x,
    input  logic signed [COORD_BITS-1:0] s_centroid_y,
    input  logic                         s_point_valid,
    input  logic                         s_frame_end,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [IDX_OUT_W-1:0]         m_track_index,
    output logic [IDX_OUT_W-1:0]         m_cluster_index,
    output logic signed [COORD_BITS-1:0] m_track_x,
    output logic signed [COORD_BITS-1:0] m_track_y,
    output logic                         m_last_result
);

    localparam int QDATA_W = CMD_W + 2 * COORD_BITS;

    logic                         q_full;
    logic                         q_push;
    logic [QDATA_W-1:0]           q_push_data;
    logic                         q_pop;
    logic [QDATA_W-1:0]           q_pop_data;
    logic                         q_not_empty;
    gta_cmd_t                     q_cmd;
    logic signed [COORD_BITS-1:0] q_x;
    logic signed [COORD_BITS-1:0] q_y;

    // front: accept and classify requests
    gta_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_centroid_x  (s_centroid_x),
        .s_centroid_y  (s_centroid_y),
        .s_point_valid (s_point_valid),
        .s_frame_end   (s_frame_end),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_push_data   (q_push_data)
    );

    // short queue decouples request intake from the association pass
    gta_queue #(
        .DATA_W (QDATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_not_empty)
    );

    // unpack queue entry: command flags on top, then x, then y
    assign q_cmd = gta_cmd_t'(q_pop_data[QDATA_W-1 -: CMD_W]);
    assign q_x   = $signed(q_pop_data[2*COORD_BITS-1:COORD_BITS]);
    assign q_y   = $signed(q_pop_data[COORD_BITS-1:0]);

    // back: frame buffer, track table, nearest-centroid search, result register
    gta_back #(
        .NUM_TRACKS (NUM_TRACKS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_not_empty),
        .q_cmd           (q_cmd),
        .q_x             (q_x),
        .q_y             (q_y),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_track_index   (m_track_index),
        .m_cluster_index (m_cluster_index),
        .m_track_x       (m_track_x),
        .m_track_y       (m_track_y),
        .m_last_result   (m_last_result)
    );

endmodule

### rtl/gta_checker.sv
// port-level checks for greedy_track_association, bound to the top level
// depends on gta_pkg and greedy_track_association

module gta_checker import gta_pkg::*; #(
    parameter int NUM_TRACKS = NUM_TRACKS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic signed [COORD_BITS-1:0] s_centroid_x,
    input logic signed [COORD_BITS-1:0] s_centroid_y,
    input logic                         s_point_valid,
    input logic                         s_frame_end,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [IDX_OUT_W-1:0]         m_track_index,
    input logic [IDX_OUT_W-1:0]         m_cluster_index,
    input logic signed [COORD_BITS-1:0] m_track_x,
    input logic signed [COORD_BITS-1:0] m_track_y,
    input logic                         m_last_result
);

    localparam int IDX_W = $clog2(NUM_TRACKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TRACKS - 1);

    logic [IDX_W-1:0]           exp_idx_reg;
    logic [IDX_W+IDX_OUT_W-1:0] exp_ext;

    assign exp_ext = {{IDX_OUT_W{1'b0}}, exp_idx_reg};

    // track slot expected on the next result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_idx_reg <= '0;
        end else if (m_valid && m_ready) begin
            exp_idx_reg <= m_last_result ? '0 : exp_idx_reg + 1'b1;
        end
    end

    // results leave in track order
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_track_index == exp_ext[IDX_OUT_W-1:0])
        else $error("result track index out of order");

    // last flag exactly on the final track
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_result == (exp_idx_reg == LAST_IDX)))
        else $error("last_result does not match final track");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_track_index)
            && $stable(m_cluster_index) && $stable(m_track_x) && $stable(m_track_y))
        else $error("stalled result changed");

    // reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a waiting request holds until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_centroid_x) && $stable(s_centroid_y)
            && $stable(s_point_valid) && $stable(s_frame_end))
        else $error("waiting request changed");

endmodule

bind greedy_track_association gta_checker #(
    .NUM_TRACKS (NUM_TRACKS),
    .COORD_BITS (COORD_BITS)
) u_gta_checker (.*);
